>>> hw/rtl/stbs_pkg.sv
package stbs_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W = 10;
  localparam int CMD_W = 2;
  localparam int DEFAULT_TABLE_DEPTH = 1024;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic append;        // store the word at the fill position
    logic clear;         // empty the table
    logic start_search;  // latch key, open the full range
    logic probe;         // read the midpoint of the live range
    logic compare;       // compare the read word and narrow the range
    logic publish;       // load the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_empty;
    logic hit;
    logic out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/stbs_ctrl.sv
module stbs_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [stbs_pkg::CMD_W-1:0]   cmd,
  input  stbs_pkg::dp_status_t         status,
  output stbs_pkg::ctrl_cmd_t          ctrl
);
  import stbs_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_CMP    = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctrl = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_APPEND: ctrl.append = 1'b1;
            CMD_CLEAR:  ctrl.clear = 1'b1;
            CMD_SEARCH: begin
              ctrl.start_search = 1'b1;
              state_next = S_CHECK;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (status.range_empty) begin
          state_next = S_RESULT;
        end else begin
          ctrl.probe = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        ctrl.compare = 1'b1;
        state_next = status.hit ? S_RESULT : S_CHECK;
      end
      S_RESULT: begin
        if (status.out_free) begin
          ctrl.publish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/stbs_datapath.sv
module stbs_datapath #(
  parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [stbs_pkg::WORD_W-1:0]  word,
  input  stbs_pkg::ctrl_cmd_t                 ctrl,
  output stbs_pkg::dp_status_t                status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                found,
  output logic [stbs_pkg::POS_W-1:0]          position
);
  import stbs_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic signed [WORD_W-1:0] mem [TABLE_DEPTH];
  logic signed [WORD_W-1:0] rdata;
  logic signed [WORD_W-1:0] key;
  logic [CW-1:0] count;
  logic [CW-1:0] lo;
  logic [CW-1:0] he;     // one past the upper end of the live range
  logic [CW-1:0] mid;
  logic [CW-1:0] mid_next;
  logic [CW-1:0] span;
  logic [AW+POS_W-1:0] mid_ext;
  logic hit;
  logic table_full;
  logic equal;

  assign table_full = (count == CW'(TABLE_DEPTH));
  assign span = he - lo - CW'(1);
  assign mid_next = lo + (span >> 1);
  assign equal = (rdata == key);
  assign mid_ext = {{POS_W{1'b0}}, mid[AW-1:0]};

  assign status.range_empty = (lo >= he);
  assign status.hit = equal;
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (ctrl.append && !table_full) begin
      mem[count[AW-1:0]] <= word;
    end
    if (ctrl.probe) begin
      rdata <= mem[mid_next[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start_search) begin
      key <= word;
      lo <= '0;
      he <= count;
    end
    if (ctrl.probe) begin
      mid <= mid_next;
    end
    if (ctrl.compare && !equal) begin
      if (rdata < key) begin
        lo <= mid + CW'(1);
      end else begin
        he <= mid;
      end
    end
    if (ctrl.publish) begin
      found <= hit;
      position <= hit ? mid_ext[POS_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      hit <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        count <= '0;
      end else if (ctrl.append && !table_full) begin
        count <= count + CW'(1);
      end
      if (ctrl.start_search) begin
        hit <= 1'b0;
      end else if (ctrl.compare && equal) begin
        hit <= 1'b1;
      end
      if (ctrl.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/sorted_table_binary_search.sv
// Append, clear and unused-code transactions can run back to back.
// A search makes at most floor(log2(loaded count)) + 1 probes, each a table read and then a compare;
// a miss then closes on the empty range, and the result is loaded into the output register.
// A stalled output register holds the search, and the input, until it is free.
// Reset clears the loaded count and the output valid flag; table contents stay undefined.
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [stbs_pkg::CMD_W-1:0]          cmd,
  input  logic signed [stbs_pkg::WORD_W-1:0]  word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                found,
  output logic [stbs_pkg::POS_W-1:0]          position
);
  import stbs_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status),
    .ctrl     (ctrl)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .word      (word),
    .ctrl      (ctrl),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .position  (position)
  );

endmodule
